### hw/rtl/lcdfb_pkg.sv
// Package for the rotated LCD framebuffer: action codes, rotation codes,
// refresh command bytes and the command/status structs between controller
// and datapath. Depends on nothing.
`default_nettype none

package lcdfb_pkg;

  typedef enum logic [1:0] {
    ACT_DRAW    = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [7:0] CMD_SET_Y = 8'h40;
  localparam logic [7:0] CMD_SET_X = 8'h80;

  typedef struct packed {
    logic capture;
    logic map;
    logic pix_rd;
    logic pix_wr;
    logic clr_start;
    logic clr_wr;
    logic rf_rd;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/lcdfb_if.sv
// Channel interfaces of the rotated LCD framebuffer: the request channel
// that carries one action item and the response channel for refresh bytes.
// Depends on lcdfb_pkg.
`default_nettype none

interface lcdfb_req_if import lcdfb_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic signed [7:0] pixel_x;
  logic signed [7:0] pixel_y;
  logic              color;

  modport source (output valid, action, pixel_x, pixel_y, color, input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, color, output ready);
endinterface

interface lcdfb_rsp_if import lcdfb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_frame;

  modport source (output valid, out_byte, is_data, last_of_frame, input ready);
  modport sink   (input valid, out_byte, is_data, last_of_frame, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcdfb_ctrl.sv
// Controller state machine of the rotated LCD framebuffer. It sequences
// draw, clear and refresh items and drives the datapath commands.
// Depends on lcdfb_pkg.
`default_nettype none

module lcdfb_ctrl import lcdfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  action_t  req_action,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MAP   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_FETCH = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (req_action)
            ACT_DRAW: state_next = S_MAP;
            ACT_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            ACT_REFRESH: state_next = S_FETCH;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        if (stat.in_range) begin
          cmd.pix_rd = 1'b1;
          state_next = S_WRITE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.pix_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_FETCH: begin
        cmd.rf_rd  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/lcdfb_dp.sv
// Datapath of the rotated LCD framebuffer: rotation register, coordinate
// mapping, frame memory, clear counter, refresh position and output register.
// Depends on lcdfb_pkg.
`default_nettype none

module lcdfb_dp import lcdfb_pkg::*; #(
  parameter int PANEL_WIDTH = 84,
  parameter int PANEL_PAGES = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic signed [7:0] req_x,
  input  logic signed [7:0] req_y,
  input  logic              req_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              is_data,
  output logic              last_of_frame
);

  localparam int PANEL_HEIGHT = PANEL_PAGES * 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int XW           = $clog2(PANEL_WIDTH);
  localparam int PG_W         = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
  localparam int YW           = PG_W + 3;
  localparam int OFF_W        = $clog2(PANEL_WIDTH + 2);

  localparam logic [7:0]        W_LEN     = 8'(PANEL_WIDTH);
  localparam logic [7:0]        H_LEN     = 8'(PANEL_HEIGHT);
  localparam logic [7:0]        W_MAX     = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0]        H_MAX     = 8'(PANEL_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(STORE_BYTES - 1);
  localparam logic [PG_W-1:0]   LAST_PAGE = PG_W'(PANEL_PAGES - 1);
  localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(PANEL_WIDTH + 1);
  localparam logic [OFF_W-1:0]  OFF_X     = OFF_W'(1);

  logic [1:0]        rotation;
  logic signed [7:0] x_q;
  logic signed [7:0] y_q;
  logic              color_q;
  logic [XW-1:0]     px_q;
  logic [YW-1:0]     py_q;
  logic              ok_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] clr_cnt;
  logic [PG_W-1:0]   page_q;
  logic [OFF_W-1:0]  off_q;
  logic [ADDR_W-1:0] base_q;
  logic [7:0]        rdata;
  logic [7:0]        mem [STORE_BYTES];

  logic [7:0]        xu;
  logic [7:0]        yu;
  logic [7:0]        lw;
  logic [7:0]        lh;
  logic              ok;
  logic [7:0]        px_m;
  logic [7:0]        py_m;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rf_addr;
  logic [7:0]        modified;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
    end else if (cfg_we) begin
      rotation <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_q     <= req_x;
      y_q     <= req_y;
      color_q <= req_color;
    end
  end

  assign xu = x_q;
  assign yu = y_q;
  assign lw = rotation[0] ? H_LEN : W_LEN;
  assign lh = rotation[0] ? W_LEN : H_LEN;
  assign ok = !x_q[7] && !y_q[7] && (xu < lw) && (yu < lh);

  always_comb begin
    case (rotation)
      ROT_0: begin
        px_m = xu;
        py_m = yu;
      end
      ROT_90: begin
        px_m = W_MAX - yu;
        py_m = xu;
      end
      ROT_180: begin
        px_m = W_MAX - xu;
        py_m = H_MAX - yu;
      end
      default: begin
        px_m = yu;
        py_m = H_MAX - xu;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_q <= 1'b0;
    end else if (cmd.map) begin
      ok_q <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      px_q <= px_m[XW-1:0];
      py_q <= py_m[YW-1:0];
    end
    if (cmd.pix_rd) begin
      addr_q <= pix_addr;
    end
  end

  assign pix_addr = ADDR_W'(py_q[YW-1:3]) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(px_q);
  assign rf_addr  = base_q + ADDR_W'(off_q) - ADDR_W'(2);

  always_comb begin
    modified = rdata;
    modified[py_q[2:0]] = color_q;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  assign mem_we    = cmd.clr_wr | cmd.pix_wr;
  assign mem_waddr = cmd.clr_wr ? clr_cnt : addr_q;
  assign mem_wdata = cmd.clr_wr ? 8'h00 : modified;
  assign mem_re    = cmd.pix_rd | cmd.rf_rd;
  assign mem_raddr = cmd.pix_rd ? pix_addr : rf_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign last = (page_q == LAST_PAGE) && (off_q == OFF_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_q <= '0;
      off_q  <= '0;
      base_q <= '0;
    end else if (cmd.emit) begin
      if (off_q == OFF_LAST) begin
        off_q <= '0;
        if (page_q == LAST_PAGE) begin
          page_q <= '0;
          base_q <= '0;
        end else begin
          page_q <= page_q + PG_W'(1);
          base_q <= base_q + ADDR_W'(PANEL_WIDTH);
        end
      end else begin
        off_q <= off_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_frame <= last;
      if (off_q == '0) begin
        out_byte <= CMD_SET_Y | 8'(page_q);
        is_data  <= 1'b0;
      end else if (off_q == OFF_X) begin
        out_byte <= CMD_SET_X;
        is_data  <= 1'b0;
      end else begin
        out_byte <= rdata;
        is_data  <= 1'b1;
      end
    end
  end

  assign stat.in_range = ok_q;
  assign stat.clr_last = (clr_cnt == CLR_LAST);
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### hw/rtl/rotated_lcd_framebuffer_refresh.sv
// Top level of the rotated LCD framebuffer: joins the controller and the
// datapath to the request, response and rotation ports.
// Depends on lcdfb_pkg, lcdfb_if, lcdfb_ctrl and lcdfb_dp.
//
//   channel   direction  carries
//   req       in         action, pixel_x, pixel_y, color
//   rsp       out        out_byte, is_data, last_of_frame
//   cfg       in         rotation (cfg_we, cfg_wdata)
//
// A draw item runs through accept, coordinate mapping, memory read and
// memory write back. A pixel out of range ends after the mapping.
// A refresh item runs through accept, memory read and load of the output
// register, and waits while the output register stays full.
// A clear item writes all PANEL_WIDTH*PANEL_PAGES bytes, one memory write a cycle.
// After reset the same clearing pass writes all PANEL_WIDTH*PANEL_PAGES bytes
// (504 by default) before the first item is accepted.
`default_nettype none

module rotated_lcd_framebuffer_refresh import lcdfb_pkg::*; #(
  parameter int PANEL_WIDTH = 84,
  parameter int PANEL_PAGES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  lcdfb_req_if.sink   req,
  lcdfb_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lcdfb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lcdfb_dp #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat),
    .req_x         (req.pixel_x),
    .req_y         (req.pixel_y),
    .req_color     (req.color),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_byte      (rsp.out_byte),
    .is_data       (rsp.is_data),
    .last_of_frame (rsp.last_of_frame)
  );

endmodule

`default_nettype wire

### hw/rtl/lcdfb_chk.sv
// Port checker of the rotated LCD framebuffer and its bind to the top level.
// Depends on lcdfb_pkg and rotated_lcd_framebuffer_refresh.
`default_nettype none

module lcdfb_chk import lcdfb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_action,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_is_data,
  input logic       rsp_last
);

  logic req_take;

  assign req_take = req_valid && req_ready;

  a_reset_busy: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("Request ready right after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Response item dropped before it was taken.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_take && req_action != ACT_NONE |=> !req_ready)
    else $error("Request ready while an item is still in work.");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_take && req_action == ACT_REFRESH, 3))
    else $error("Response item without a refresh item three cycles earlier.");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_last |-> rsp_is_data)
    else $error("End of frame marked on a command byte.");

endmodule

bind rotated_lcd_framebuffer_refresh lcdfb_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_action  (req.action),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_is_data (rsp.is_data),
  .rsp_last    (rsp.last_of_frame)
);

`default_nettype wire

### test/tb_rotated_lcd_framebuffer_refresh.sv
// Testbench for rotated_lcd_framebuffer_refresh: draws, clears and refresh reads under all
// four rotations, each refresh byte checked against a local framebuffer mirror or a typed
// expected byte. Depends on lcdfb_pkg, lcdfb_if and the block's RTL.

module tb_rotated_lcd_framebuffer_refresh import lcdfb_pkg::*; ();

  localparam int PANEL_WIDTH  = 84;
  localparam int PANEL_PAGES  = 6;
  localparam int PANEL_HEIGHT = PANEL_PAGES * 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
  localparam int PAGE_LEN     = PANEL_WIDTH + 2;
  localparam int FRAME_LEN    = PANEL_PAGES * PAGE_LEN;
  localparam int SETTLE       = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 185;
  localparam int NUM_ROWS     = 23;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic       typed;
    lcd_byte_t  want;
  } lcd_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  lcdfb_req_if req ();
  lcdfb_rsp_if rsp ();

  rotated_lcd_framebuffer_refresh #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  logic [7:0] fb_mirror [STORE_BYTES];
  int         stream_pos;
  logic [1:0] rot_cfg;
  lcd_byte_t  pending_bytes [$];
  int         errors;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         hold_asks;

  // Coordinates in hex: 8'h53/8'h2F is the far corner (83, 47), 8'hFF is -1, 8'h80 is -128.
  lcd_row_t directed_rows [NUM_ROWS] = '{
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1, '{CMD_SET_Y, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1, '{CMD_SET_X, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ACT_DRAW,    8'h00, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h53, 8'h2F, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h54, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h00, 8'h30, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'hFF, 8'h05, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h05, 8'h80, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h7F, 8'h7F, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h80, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h01, 8'h07, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h01, 8'h07, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_DRAW,    8'h02, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_NONE,    8'hFF, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_CLEAR,   8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ACT_DRAW,    8'h03, 8'h08, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{ACT_CLEAR,   8'h00, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void mirror_draw(logic signed [7:0] x, logic signed [7:0] y, logic c);
    int xi, yi, lw, lh, px, py;
    xi = x;
    yi = y;
    lw = rot_cfg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    lh = rot_cfg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    if (xi < 0 || xi >= lw || yi < 0 || yi >= lh) return;
    case (rot_cfg)
      ROT_0: begin
        px = xi;
        py = yi;
      end
      ROT_90: begin
        px = PANEL_WIDTH - 1 - yi;
        py = xi;
      end
      ROT_180: begin
        px = PANEL_WIDTH - 1 - xi;
        py = PANEL_HEIGHT - 1 - yi;
      end
      default: begin
        px = yi;
        py = PANEL_HEIGHT - 1 - xi;
      end
    endcase
    fb_mirror[px + (py / 8) * PANEL_WIDTH][py % 8] = c;
  endfunction

  function automatic lcd_byte_t next_stream_byte();
    lcd_byte_t r;
    int pg, off;
    pg = stream_pos / PAGE_LEN;
    off = stream_pos % PAGE_LEN;
    r.last = (stream_pos == FRAME_LEN - 1);
    if (off == 0) begin
      r.value = CMD_SET_Y | 8'(pg);
      r.is_data = 1'b0;
    end else if (off == 1) begin
      r.value = CMD_SET_X;
      r.is_data = 1'b0;
    end else begin
      r.value = fb_mirror[pg * PANEL_WIDTH + off - 2];
      r.is_data = 1'b1;
    end
    stream_pos = r.last ? 0 : stream_pos + 1;
    return r;
  endfunction

  task automatic send_item(action_t a, logic [7:0] x, logic [7:0] y, logic c,
                           logic typed, lcd_byte_t want);
    lcd_byte_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.action  <= a;
    req.pixel_x <= x;
    req.pixel_y <= y;
    req.color   <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (a)
      ACT_DRAW: mirror_draw(x, y, c);
      ACT_CLEAR: for (int i = 0; i < STORE_BYTES; i++) fb_mirror[i] = 8'h00;
      ACT_REFRESH: begin
        got = next_stream_byte();
        pending_bytes.push_back(typed ? want : got);
      end
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rotation(logic [1:0] r);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rot_cfg = r;
  endtask

  task automatic random_item();
    int p, lw, lh;
    lw = rot_cfg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    lh = rot_cfg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    p = $urandom_range(99);
    if (p < 34) begin
      send_item(ACT_DRAW, 8'($urandom_range(lw - 1)), 8'($urandom_range(lh - 1)),
                1'($urandom_range(3) != 0), 1'b0, '0);
    end else if (p < 93) begin
      send_item(ACT_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    end else if (p < 94) begin
      send_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    end else if (p < 96) begin
      send_item(ACT_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    end else begin
      send_item(ACT_DRAW, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    end
  endtask

  initial begin : rsp_sink
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    lcd_byte_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.out_byte, rsp.is_data, rsp.last_of_frame};
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected refresh byte %02h data=%0b last=%0b",
                 $time, got.value, got.is_data, got.last);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.value, got.value);
          errors++;
        end
        if (got.is_data !== want.is_data) begin
          $display("%0t: is_data expected %0b actual %0b", $time, want.is_data, got.is_data);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL rotated_lcd_framebuffer_refresh");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] phase_rot [PHASES];
    phase_rot    = '{ROT_270, ROT_90, ROT_180, ROT_0, ROT_270, ROT_90};
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = ROT_0;
    req.valid    = 1'b0;
    req.action   = ACT_NONE;
    req.pixel_x  = 8'h00;
    req.pixel_y  = 8'h00;
    req.color    = 1'b0;
    errors       = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_asks    = 0;
    stream_pos   = 0;
    rot_cfg      = ROT_0;
    for (int i = 0; i < STORE_BYTES; i++) fb_mirror[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_rotation(ROT_0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].color, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      req.valid <= 1'b0;
      drain_and_settle();
      write_rotation(phase_rot[ph]);
      src_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 52 : 0;
      snk_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 37 : 0;
      if (ph == 4) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    req.valid <= 1'b0;
    drain_and_settle();
    if (errors == 0) $display("PASS rotated_lcd_framebuffer_refresh");
    else $display("FAIL rotated_lcd_framebuffer_refresh");
    $finish;
  end

endmodule
